### src/mqa_pkg.sv
`timescale 1ns / 1ps
package mqa_pkg;

    // Sizes of the stores; all powers of two, so addresses are {row, slot}.
    localparam int NUM_CONVERSATIONS = 16;
    localparam int QUEUE_DEPTH       = 16;
    localparam int NUM_SENDERS       = 16;
    localparam int RATE_DEPTH        = 8;
    localparam int DUP_ENTRIES       = 64;

    localparam int CONV_W  = $clog2(NUM_CONVERSATIONS);
    localparam int QPOS_W  = $clog2(QUEUE_DEPTH);
    localparam int SEND_W  = $clog2(NUM_SENDERS);
    localparam int RPOS_W  = $clog2(RATE_DEPTH);
    localparam int DUP_W   = $clog2(DUP_ENTRIES);
    localparam int QADDR_W = CONV_W + QPOS_W;
    localparam int RADDR_W = SEND_W + RPOS_W;

    // queue entry: item id, sender, digest, digest present
    localparam int QENTRY_W = 64 + SEND_W + 32 + 1;
    // duplicate entry: conversation, sender, digest, stamp
    localparam int DENTRY_W = CONV_W + SEND_W + 32 + 48;

    typedef enum logic [1:0] {
        ACT_ENQUEUE   = 2'd0,
        ACT_TAKE_NEXT = 2'd1,
        ACT_TAKE_FOR  = 2'd2,
        ACT_QUERY     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_DUPLICATE    = 3'd1,
        ST_RATE_LIMITED = 3'd2,
        ST_CONV_FULL    = 3'd3,
        ST_TOTAL_FULL   = 3'd4,
        ST_TAKEN        = 3'd5,
        ST_NONE         = 3'd6
    } status_t;

    localparam logic [2:0] CFG_DUP_WINDOW  = 3'd0;
    localparam logic [2:0] CFG_RATE_MAX    = 3'd1;
    localparam logic [2:0] CFG_RATE_WINDOW = 3'd2;
    localparam logic [2:0] CFG_MAX_PER_CONV = 3'd3;
    localparam logic [2:0] CFG_MAX_TOTAL   = 3'd4;

endpackage

### src/mqa_ram.sv
`timescale 1ns / 1ps
module mqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/multi_queue_admission_round_robin_top.sv
`timescale 1ns / 1ps
// From the accepting edge to the result on the output: a query goes straight to the result;
// take_for pops the head and reads its entry (no read when empty); take_next scans the serve
// order from the cursor (no scan with no conversation seen, all slots when none is pending);
// enqueue runs the duplicate scan, reads and checks each rate stamp, then admits. Throughput:
// one beat at a time; the next is taken the cycle after a result enters the output register,
// so the duplicate scan sets the pace. Reset: asynchronous, active low; counts, pointers and
// valid bits clear at once, no clearing pass; a beat is taken in the first cycle after reset.
module multi_queue_admission_round_robin_top
    import mqa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic signed [63:0] item_id,
    input  logic [3:0]  conversation,
    input  logic [3:0]  sender,
    input  logic [31:0] digest,
    input  logic        digest_present,
    input  logic [47:0] now_ms,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic signed [63:0] out_item_id,
    output logic [3:0]  out_conversation,
    output logic [3:0]  out_sender,
    output logic [31:0] out_digest,
    output logic        out_digest_present,
    output logic [8:0]  pending_all,
    output logic [4:0]  pending_this
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_SCAN,
        S_RATE_RD,
        S_RATE_CHK,
        S_ADMIT,
        S_TAKE_FOR,
        S_TN_SCAN,
        S_POP_DATA,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [31:0] dup_win_reg;
    logic [3:0]  rate_max_reg;
    logic [31:0] rate_win_reg;
    logic [4:0]  max_conv_reg;
    logic [8:0]  max_total_reg;

    // latched beat
    logic [63:0]         id_reg;
    logic [CONV_W-1:0]   c_reg;
    logic [SEND_W-1:0]   s_reg;
    logic [31:0]         dg_reg;
    logic                dp_reg;
    logic [47:0]         now_reg;

    // queue bookkeeping
    logic [QPOS_W-1:0]   q_head_reg  [NUM_CONVERSATIONS];
    logic [QPOS_W:0]     q_count_reg [NUM_CONVERSATIONS];
    logic [8:0]          total_reg;
    logic [CONV_W-1:0]   serve_reg   [NUM_CONVERSATIONS];
    logic [CONV_W:0]     serve_len_reg;
    logic [NUM_CONVERSATIONS-1:0] seen_reg;
    logic [CONV_W-1:0]   rr_reg;
    logic [CONV_W-1:0]   cur_reg;
    logic [CONV_W:0]     step_reg;

    // sender rate windows
    logic [RPOS_W-1:0]   r_head_reg  [NUM_SENDERS];
    logic [RPOS_W:0]     r_count_reg [NUM_SENDERS];

    // duplicate table scan
    logic [DUP_ENTRIES-1:0] dup_valid_reg;
    logic [DUP_W:0]      scan_idx_reg;
    logic                chk_vld_reg;
    logic [DUP_W-1:0]    chk_idx_reg;
    logic                hit_f_reg;
    logic                hit_exp_reg;
    logic [DUP_W-1:0]    hit_idx_reg;
    logic                inv_f_reg;
    logic [DUP_W-1:0]    inv_idx_reg;
    logic                exp_f_reg;
    logic [DUP_W-1:0]    exp_idx_reg;
    logic [DUP_W-1:0]    old_idx_reg;
    logic [47:0]         old_st_reg;

    // result held until the output register is free
    status_t             res_status_reg;
    logic [63:0]         res_id_reg;
    logic [CONV_W-1:0]   res_conv_reg;
    logic [SEND_W-1:0]   res_sender_reg;
    logic [31:0]         res_dg_reg;
    logic                res_dp_reg;

    // output register
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [63:0]         out_id_reg;
    logic [CONV_W-1:0]   out_conv_reg;
    logic [SEND_W-1:0]   out_sender_reg;
    logic [31:0]         out_dg_reg;
    logic                out_dp_reg;
    logic [8:0]          out_all_reg;
    logic [4:0]          out_this_reg;

    // elapsed(now, stamp) >= window, with time running backwards counting as zero
    function automatic logic expired(input logic [47:0] now, input logic [47:0] stamp,
                                     input logic [31:0] win);
        logic [47:0] diff;
        diff = now - stamp;
        if (now >= stamp)
        begin
            return diff >= {16'd0, win};
        end
        return win == 32'd0;
    endfunction

    // ------------------------------------------------------------------
    // Shared read port on the per-conversation counters: the scan
    // looks at serve order, everything else at the beat's conversation.
    // ------------------------------------------------------------------
    logic [CONV_W-1:0] qsel;
    logic [QPOS_W:0]   qcnt;
    logic [QPOS_W-1:0] qhead;

    assign qsel  = (state_reg == S_TN_SCAN) ? serve_reg[cur_reg] : c_reg;
    assign qcnt  = q_count_reg[qsel];
    assign qhead = q_head_reg[qsel];

    logic       dup_on;
    logic       rate_on;
    logic [3:0] rate_cap;

    assign dup_on   = (dup_win_reg != 32'd0) && dp_reg;
    assign rate_on  = (rate_max_reg != 4'd0) && (rate_win_reg != 32'd0);
    assign rate_cap = (rate_max_reg < 4'(RATE_DEPTH)) ? rate_max_reg : 4'(RATE_DEPTH);

    logic [RPOS_W-1:0] rhead;
    logic [RPOS_W:0]   rcnt;
    assign rhead = r_head_reg[s_reg];
    assign rcnt  = r_count_reg[s_reg];

    // admission checks on the conversation and the total
    logic conv_full;
    logic total_full;
    assign conv_full  = (qcnt >= (QPOS_W + 1)'(QUEUE_DEPTH)) ||
                        ((max_conv_reg != 5'd0) && ({1'b0, qcnt} >= max_conv_reg));
    assign total_full = (max_total_reg != 9'd0) && (total_reg >= max_total_reg);

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                q_we, q_re;
    logic [QADDR_W-1:0]  q_waddr, q_raddr;
    logic [QENTRY_W-1:0] q_wdata, q_rdata;

    logic                r_we, r_re;
    logic [RADDR_W-1:0]  r_waddr, r_raddr;
    logic [47:0]         r_rdata;

    logic                d_we, d_re;
    logic [DUP_W-1:0]    d_slot;
    logic [DENTRY_W-1:0] d_wdata, d_rdata;

    logic admit_ok;
    assign admit_ok = (state_reg == S_ADMIT) && !conv_full && !total_full;

    // tail slot: head plus count wraps naturally at a power-of-two depth
    assign q_we    = admit_ok;
    assign q_waddr = {c_reg, QPOS_W'(qhead + qcnt[QPOS_W-1:0])};
    assign q_wdata = {id_reg, s_reg, dg_reg, dp_reg};
    assign q_re    = ((state_reg == S_TN_SCAN) || (state_reg == S_TAKE_FOR)) &&
                     (qcnt != '0);
    assign q_raddr = {qsel, qhead};

    assign r_we    = admit_ok && rate_on;
    assign r_waddr = {s_reg, RPOS_W'(rhead + rcnt[RPOS_W-1:0])};
    assign r_re    = (state_reg == S_RATE_RD) && (rcnt != '0);
    assign r_raddr = {s_reg, rhead};

    // record slot: matching key, else a free entry, else an expired one, else the oldest
    assign d_slot  = hit_f_reg ? hit_idx_reg :
                     inv_f_reg ? inv_idx_reg :
                     exp_f_reg ? exp_idx_reg : old_idx_reg;
    assign d_we    = admit_ok && dup_on;
    assign d_wdata = {c_reg, s_reg, dg_reg, now_reg};
    assign d_re    = (state_reg == S_DUP_SCAN) && !scan_idx_reg[DUP_W];

    mqa_ram #(.WIDTH(QENTRY_W), .DEPTH(NUM_CONVERSATIONS * QUEUE_DEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mqa_ram #(.WIDTH(48), .DEPTH(NUM_SENDERS * RATE_DEPTH)) u_rate_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (now_reg),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    mqa_ram #(.WIDTH(DENTRY_W), .DEPTH(DUP_ENTRIES)) u_dup_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_slot),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (scan_idx_reg[DUP_W-1:0]),
        .rdata (d_rdata)
    );

    // scan data for the entry read in the previous cycle
    logic        d_match;
    logic        d_exp;
    logic [47:0] d_stamp;
    assign d_stamp = d_rdata[47:0];
    assign d_match = dup_valid_reg[chk_idx_reg] &&
                     (d_rdata[DENTRY_W-1:48] == {c_reg, s_reg, dg_reg});
    assign d_exp   = expired(now_reg, d_stamp, dup_win_reg);

    logic in_fire;
    logic out_free;
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dup_win_reg    <= '0;
            rate_max_reg   <= '0;
            rate_win_reg   <= '0;
            max_conv_reg   <= '0;
            max_total_reg  <= '0;
            id_reg         <= '0;
            c_reg          <= '0;
            s_reg          <= '0;
            dg_reg         <= '0;
            dp_reg         <= 1'b0;
            now_reg        <= '0;
            for (int i = 0; i < NUM_CONVERSATIONS; i++)
            begin
                q_head_reg[i]  <= '0;
                q_count_reg[i] <= '0;
                serve_reg[i]   <= '0;
            end
            for (int i = 0; i < NUM_SENDERS; i++)
            begin
                r_head_reg[i]  <= '0;
                r_count_reg[i] <= '0;
            end
            total_reg      <= '0;
            serve_len_reg  <= '0;
            seen_reg       <= '0;
            rr_reg         <= '0;
            cur_reg        <= '0;
            step_reg       <= '0;
            dup_valid_reg  <= '0;
            scan_idx_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            hit_f_reg      <= 1'b0;
            hit_exp_reg    <= 1'b0;
            hit_idx_reg    <= '0;
            inv_f_reg      <= 1'b0;
            inv_idx_reg    <= '0;
            exp_f_reg      <= 1'b0;
            exp_idx_reg    <= '0;
            old_idx_reg    <= '0;
            old_st_reg     <= '0;
            res_status_reg <= ST_NONE;
            res_id_reg     <= '0;
            res_conv_reg   <= '0;
            res_sender_reg <= '0;
            res_dg_reg     <= '0;
            res_dp_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_NONE;
            out_id_reg     <= '0;
            out_conv_reg   <= '0;
            out_sender_reg <= '0;
            out_dg_reg     <= '0;
            out_dp_reg     <= 1'b0;
            out_all_reg    <= '0;
            out_this_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DUP_WINDOW:   dup_win_reg   <= cfg_data;
                    CFG_RATE_MAX:     rate_max_reg  <= cfg_data[3:0];
                    CFG_RATE_WINDOW:  rate_win_reg  <= cfg_data;
                    CFG_MAX_PER_CONV: max_conv_reg  <= cfg_data[4:0];
                    CFG_MAX_TOTAL:    max_total_reg <= cfg_data[8:0];
                    default:          ;
                endcase
            end

            // a new result loads as the old one leaves, or into an empty register
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        id_reg         <= item_id;
                        c_reg          <= conversation;
                        s_reg          <= sender;
                        dg_reg         <= digest;
                        dp_reg         <= digest_present;
                        now_reg        <= now_ms;
                        res_status_reg <= ST_NONE;
                        res_id_reg     <= '0;
                        res_conv_reg   <= '0;
                        res_sender_reg <= '0;
                        res_dg_reg     <= '0;
                        res_dp_reg     <= 1'b0;
                        scan_idx_reg   <= '0;
                        chk_vld_reg    <= 1'b0;
                        hit_f_reg      <= 1'b0;
                        inv_f_reg      <= 1'b0;
                        exp_f_reg      <= 1'b0;
                        cur_reg        <= rr_reg;
                        step_reg       <= '0;
                        case (action_t'(action))
                            ACT_ENQUEUE:
                            begin
                                if ((dup_win_reg != 32'd0) && digest_present)
                                begin
                                    state_reg <= S_DUP_SCAN;
                                end
                                else if (rate_on)
                                begin
                                    state_reg <= S_RATE_RD;
                                end
                                else
                                begin
                                    state_reg <= S_ADMIT;
                                end
                            end
                            ACT_TAKE_NEXT:
                            begin
                                state_reg <= (serve_len_reg == '0) ? S_DONE : S_TN_SCAN;
                            end
                            ACT_TAKE_FOR:
                            begin
                                state_reg <= S_TAKE_FOR;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_DUP_SCAN:
                begin
                    // read one entry per cycle, check the one read in the previous cycle
                    if (!scan_idx_reg[DUP_W])
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    chk_vld_reg <= !scan_idx_reg[DUP_W];
                    chk_idx_reg <= scan_idx_reg[DUP_W-1:0];
                    if (chk_vld_reg)
                    begin
                        if (d_match && !hit_f_reg)
                        begin
                            hit_f_reg   <= 1'b1;
                            hit_idx_reg <= chk_idx_reg;
                            hit_exp_reg <= d_exp;
                        end
                        if (!dup_valid_reg[chk_idx_reg] && !inv_f_reg)
                        begin
                            inv_f_reg   <= 1'b1;
                            inv_idx_reg <= chk_idx_reg;
                        end
                        if (d_exp && !exp_f_reg)
                        begin
                            exp_f_reg   <= 1'b1;
                            exp_idx_reg <= chk_idx_reg;
                        end
                        if ((chk_idx_reg == '0) || (d_stamp < old_st_reg))
                        begin
                            old_idx_reg <= chk_idx_reg;
                            old_st_reg  <= d_stamp;
                        end
                    end
                    else if (scan_idx_reg[DUP_W])
                    begin
                        if (hit_f_reg && !hit_exp_reg)
                        begin
                            res_status_reg <= ST_DUPLICATE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= rate_on ? S_RATE_RD : S_ADMIT;
                        end
                    end
                end

                S_RATE_RD:
                begin
                    if (rcnt != '0)
                    begin
                        state_reg <= S_RATE_CHK;
                    end
                    else if ({1'b0, rcnt} >= rate_cap)
                    begin
                        res_status_reg <= ST_RATE_LIMITED;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_ADMIT;
                    end
                end

                S_RATE_CHK:
                begin
                    // expired stamps leave even if the beat is then refused
                    if (expired(now_reg, r_rdata, rate_win_reg))
                    begin
                        r_head_reg[s_reg]  <= rhead + 1'b1;
                        r_count_reg[s_reg] <= rcnt - 1'b1;
                        state_reg          <= S_RATE_RD;
                    end
                    else if ({1'b0, rcnt} >= rate_cap)
                    begin
                        res_status_reg <= ST_RATE_LIMITED;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_ADMIT;
                    end
                end

                S_ADMIT:
                begin
                    if (conv_full)
                    begin
                        res_status_reg <= ST_CONV_FULL;
                    end
                    else if (total_full)
                    begin
                        res_status_reg <= ST_TOTAL_FULL;
                    end
                    else
                    begin
                        res_status_reg     <= ST_ACCEPTED;
                        q_count_reg[c_reg] <= qcnt + 1'b1;
                        total_reg          <= total_reg + 1'b1;
                        if (!seen_reg[c_reg])
                        begin
                            seen_reg[c_reg]                     <= 1'b1;
                            serve_reg[serve_len_reg[CONV_W-1:0]] <= c_reg;
                            serve_len_reg                       <= serve_len_reg + 1'b1;
                        end
                        if (rate_on)
                        begin
                            r_count_reg[s_reg] <= rcnt + 1'b1;
                        end
                        if (dup_on)
                        begin
                            dup_valid_reg[d_slot] <= 1'b1;
                        end
                    end
                    state_reg <= S_DONE;
                end

                S_TAKE_FOR:
                begin
                    if (qcnt != '0)
                    begin
                        q_head_reg[qsel]  <= qhead + 1'b1;
                        q_count_reg[qsel] <= qcnt - 1'b1;
                        total_reg         <= total_reg - 1'b1;
                        res_conv_reg      <= qsel;
                        state_reg         <= S_POP_DATA;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_TN_SCAN:
                begin
                    // one serve-order slot per cycle from the cursor
                    if (qcnt != '0)
                    begin
                        q_head_reg[qsel]  <= qhead + 1'b1;
                        q_count_reg[qsel] <= qcnt - 1'b1;
                        total_reg         <= total_reg - 1'b1;
                        res_conv_reg      <= qsel;
                        rr_reg            <= ({1'b0, cur_reg} == serve_len_reg - 1'b1) ?
                                             '0 : cur_reg + 1'b1;
                        state_reg         <= S_POP_DATA;
                    end
                    else
                    begin
                        cur_reg <= ({1'b0, cur_reg} == serve_len_reg - 1'b1) ?
                                   '0 : cur_reg + 1'b1;
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == serve_len_reg - 1'b1)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_POP_DATA:
                begin
                    res_status_reg <= ST_TAKEN;
                    res_id_reg     <= q_rdata[QENTRY_W-1 -: 64];
                    res_sender_reg <= q_rdata[32 + 1 +: SEND_W];
                    res_dg_reg     <= q_rdata[1 +: 32];
                    res_dp_reg     <= q_rdata[0];
                    state_reg      <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_id_reg     <= res_id_reg;
                        out_conv_reg   <= res_conv_reg;
                        out_sender_reg <= res_sender_reg;
                        out_dg_reg     <= res_dg_reg;
                        out_dp_reg     <= res_dp_reg;
                        out_all_reg    <= total_reg;
                        out_this_reg   <= 5'(qcnt);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall           = (state_reg != S_IDLE);
    assign out_valid          = out_valid_reg;
    assign status             = out_status_reg;
    assign out_item_id        = out_id_reg;
    assign out_conversation   = out_conv_reg;
    assign out_sender         = out_sender_reg;
    assign out_digest         = out_dg_reg;
    assign out_digest_present = out_dp_reg;
    assign pending_all        = out_all_reg;
    assign pending_this       = out_this_reg;

endmodule

### src/mqa_checker.sv
`timescale 1ns / 1ps
module mqa_checker
    import mqa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic signed [63:0] out_item_id,
    input logic [3:0]  out_sender,
    input logic [31:0] out_digest,
    input logic        out_digest_present,
    input logic [8:0]  pending_all,
    input logic [4:0]  pending_this
);

    // a taken beat keeps the block busy for at least the next cycle
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while the previous beat is in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(pending_all))
        else $error("result changed under stall");

    // only a taken beat carries item fields
    a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_TAKEN) |->
            (out_item_id == 64'sd0) && (out_sender == 4'd0) && (out_digest == 32'd0) &&
            !out_digest_present)
        else $error("item fields set without a take");

    // a conversation never holds more than the total or the queue depth
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({4'd0, pending_this} <= pending_all) &&
                      (pending_this <= 5'(QUEUE_DEPTH)))
        else $error("pending counts inconsistent");

    // an accepted enqueue leaves at least one item pending
    a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ACCEPTED) |-> (pending_this != 5'd0))
        else $error("accepted item not counted");

endmodule

bind multi_queue_admission_round_robin_top mqa_checker u_mqa_checker (.*);

### bench/tb_multi_queue_admission_round_robin_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the multi-queue admission block.
// A scoreboard object predicts every result as the input beat is taken; the output
// monitor takes the oldest prediction and compares field by field.
module tb_multi_queue_admission_round_robin_top;
    import mqa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
    localparam int DRAIN_CYCLES   = 120;   // margin for the longest enqueue, duplicate scan and rate reads included
    localparam int LONG_HOLD      = 400;

    typedef struct {
        action_t            act;
        logic signed [63:0] id;
        logic [3:0]         conv;
        logic [3:0]         snd;
        logic [31:0]        dig;
        logic               dp;
        logic [47:0]        now;
    } request_t;

    typedef struct {
        status_t            st;
        logic signed [63:0] id;
        logic [3:0]         conv;
        logic [3:0]         snd;
        logic [31:0]        dig;
        logic               dp;
        logic [8:0]         all_cnt;
        logic [4:0]         conv_cnt;
    } outcome_t;

    // Predictor of queue, rate and duplicate state plus the store of outcomes due.
    class admission_scoreboard;
        logic [31:0] dup_win;
        logic [3:0]  rate_cap_reg;
        logic [31:0] rate_win;
        logic [4:0]  conv_cap;
        logic [8:0]  total_cap;

        logic [63:0] q_id  [NUM_CONVERSATIONS][QUEUE_DEPTH];
        logic [3:0]  q_snd [NUM_CONVERSATIONS][QUEUE_DEPTH];
        logic [31:0] q_dig [NUM_CONVERSATIONS][QUEUE_DEPTH];
        logic        q_dp  [NUM_CONVERSATIONS][QUEUE_DEPTH];
        int unsigned q_head[NUM_CONVERSATIONS];
        int unsigned q_cnt [NUM_CONVERSATIONS];
        int unsigned total;
        int unsigned order [NUM_CONVERSATIONS];
        int unsigned order_len;
        int unsigned cursor;

        logic [47:0] r_stamp[NUM_SENDERS][RATE_DEPTH];
        int unsigned r_head [NUM_SENDERS];
        int unsigned r_cnt  [NUM_SENDERS];

        logic        d_valid[DUP_ENTRIES];
        logic [3:0]  d_snd  [DUP_ENTRIES];
        logic [3:0]  d_conv [DUP_ENTRIES];
        logic [31:0] d_dig  [DUP_ENTRIES];
        logic [47:0] d_stamp[DUP_ENTRIES];

        outcome_t due[$];
        int       errors;

        function new();
            dup_win = 0; rate_cap_reg = 0; rate_win = 0; conv_cap = 0; total_cap = 0;
            total = 0; order_len = 0; cursor = 0; errors = 0;
            foreach (q_head[i]) begin q_head[i] = 0; q_cnt[i] = 0; order[i] = 0; end
            foreach (r_head[i]) begin r_head[i] = 0; r_cnt[i] = 0; end
            foreach (d_valid[i]) begin d_valid[i] = 0; d_stamp[i] = 0; end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_DUP_WINDOW:   dup_win      = val;
                CFG_RATE_MAX:     rate_cap_reg = val[3:0];
                CFG_RATE_WINDOW:  rate_win     = val;
                CFG_MAX_PER_CONV: conv_cap     = val[4:0];
                CFG_MAX_TOTAL:    total_cap    = val[8:0];
                default: ;
            endcase
        endfunction

        // time since a stamp; clock going backwards counts as no time
        function logic [47:0] age(logic [47:0] now, logic [47:0] stamp);
            return (now >= stamp) ? now - stamp : 48'd0;
        endfunction

        function int dup_lookup(logic [3:0] s, logic [3:0] c, logic [31:0] d);
            for (int i = 0; i < DUP_ENTRIES; i++)
                if (d_valid[i] && d_snd[i] == s && d_conv[i] == c && d_dig[i] == d)
                    return i;
            return -1;
        endfunction

        // reuse own key, else a free slot, else an expired one, else the oldest
        function void dup_store(logic [3:0] s, logic [3:0] c, logic [31:0] d,
                                logic [47:0] now);
            int slot;
            slot = dup_lookup(s, c, d);
            for (int i = 0; i < DUP_ENTRIES && slot < 0; i++)
                if (!d_valid[i]) slot = i;
            for (int i = 0; i < DUP_ENTRIES && slot < 0; i++)
                if (age(now, d_stamp[i]) >= {16'd0, dup_win}) slot = i;
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < DUP_ENTRIES; i++)
                    if (d_stamp[i] < d_stamp[slot]) slot = i;
            end
            d_valid[slot] = 1'b1;
            d_snd[slot]   = s;
            d_conv[slot]  = c;
            d_dig[slot]   = d;
            d_stamp[slot] = now;
        endfunction

        function status_t admit(request_t t);
            bit          dup_on;
            bit          rate_on;
            bit          seen;
            int          hit;
            int unsigned cap;
            int unsigned pos;
            dup_on  = (dup_win != 0) && t.dp;
            rate_on = (rate_cap_reg != 0) && (rate_win != 0);
            if (dup_on)
            begin
                hit = dup_lookup(t.snd, t.conv, t.dig);
                if (hit >= 0 && age(t.now, d_stamp[hit]) < {16'd0, dup_win})
                    return ST_DUPLICATE;
            end
            if (rate_on)
            begin
                cap = (rate_cap_reg < RATE_DEPTH) ? rate_cap_reg : RATE_DEPTH;
                // stale stamps go even if this beat is then refused
                while (r_cnt[t.snd] > 0 &&
                       age(t.now, r_stamp[t.snd][r_head[t.snd]]) >= {16'd0, rate_win})
                begin
                    r_head[t.snd] = (r_head[t.snd] + 1) % RATE_DEPTH;
                    r_cnt[t.snd]--;
                end
                if (r_cnt[t.snd] >= cap)
                    return ST_RATE_LIMITED;
            end
            if (q_cnt[t.conv] >= QUEUE_DEPTH || (conv_cap != 0 && q_cnt[t.conv] >= conv_cap))
                return ST_CONV_FULL;
            if (total_cap != 0 && total >= total_cap)
                return ST_TOTAL_FULL;

            pos = (q_head[t.conv] + q_cnt[t.conv]) % QUEUE_DEPTH;
            q_id[t.conv][pos]  = t.id;
            q_snd[t.conv][pos] = t.snd;
            q_dig[t.conv][pos] = t.dig;
            q_dp[t.conv][pos]  = t.dp;
            q_cnt[t.conv]++;
            total++;
            seen = 0;
            for (int unsigned i = 0; i < order_len; i++)
                if (order[i] == t.conv) seen = 1;
            if (!seen && order_len < NUM_CONVERSATIONS)
            begin
                order[order_len] = t.conv;
                order_len++;
            end
            if (rate_on)
            begin
                r_stamp[t.snd][(r_head[t.snd] + r_cnt[t.snd]) % RATE_DEPTH] = t.now;
                r_cnt[t.snd]++;
            end
            if (dup_on)
                dup_store(t.snd, t.conv, t.dig, t.now);
            return ST_ACCEPTED;
        endfunction

        function void pop_head(int unsigned c, ref outcome_t o);
            int unsigned h;
            h      = q_head[c];
            o.st   = ST_TAKEN;
            o.id   = q_id[c][h];
            o.conv = c[3:0];
            o.snd  = q_snd[c][h];
            o.dig  = q_dig[c][h];
            o.dp   = q_dp[c][h];
            q_head[c] = (h + 1) % QUEUE_DEPTH;
            q_cnt[c]--;
            total--;
        endfunction

        // called for every input beat taken
        function void note_request(request_t t);
            outcome_t    o;
            int unsigned cur;
            int unsigned idx;
            o = '{st: ST_NONE, id: 0, conv: 0, snd: 0, dig: 0, dp: 0, all_cnt: 0, conv_cnt: 0};
            case (t.act)
                ACT_ENQUEUE: o.st = admit(t);
                ACT_TAKE_NEXT:
                begin
                    if (order_len > 0)
                    begin
                        cur = cursor % order_len;
                        for (int unsigned k = 0; k < order_len; k++)
                        begin
                            idx = cur;
                            cur = (idx + 1) % order_len;
                            if (q_cnt[order[idx]] > 0)
                            begin
                                pop_head(order[idx], o);
                                break;
                            end
                        end
                        cursor = cur;
                    end
                end
                ACT_TAKE_FOR:
                    if (q_cnt[t.conv] > 0)
                        pop_head(t.conv, o);
                default: ;
            endcase
            o.all_cnt  = total[8:0];
            o.conv_cnt = q_cnt[t.conv][4:0];
            due.insert(due.size(), o);
        endfunction

        // called for every result beat taken
        function void check_result(outcome_t got);
            outcome_t w;
            if (due.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                errors++;
                return;
            end
            w = due[0];
            due.delete(0);
            if (got.st !== w.st)
            begin $error("status exp %0d got %0d", w.st, got.st); errors++; end
            if (got.id !== w.id)
            begin $error("out_item_id exp %0h got %0h", w.id, got.id); errors++; end
            if (got.conv !== w.conv)
            begin $error("out_conversation exp %0d got %0d", w.conv, got.conv); errors++; end
            if (got.snd !== w.snd)
            begin $error("out_sender exp %0d got %0d", w.snd, got.snd); errors++; end
            if (got.dig !== w.dig)
            begin $error("out_digest exp %0h got %0h", w.dig, got.dig); errors++; end
            if (got.dp !== w.dp)
            begin $error("out_digest_present exp %0d got %0d", w.dp, got.dp); errors++; end
            if (got.all_cnt !== w.all_cnt)
            begin $error("pending_all exp %0d got %0d", w.all_cnt, got.all_cnt); errors++; end
            if (got.conv_cnt !== w.conv_cnt)
            begin $error("pending_this exp %0d got %0d", w.conv_cnt, got.conv_cnt); errors++; end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [63:0] item_id;
    logic [3:0]         conversation;
    logic [3:0]         sender;
    logic [31:0]        digest;
    logic               digest_present;
    logic [47:0]        now_ms;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic signed [63:0] out_item_id;
    logic [3:0]         out_conversation;
    logic [3:0]         out_sender;
    logic [31:0]        out_digest;
    logic               out_digest_present;
    logic [8:0]         pending_all;
    logic [4:0]         pending_this;

    admission_scoreboard sb;
    bit          idle_on;     // random gaps on both channels
    bit          hold_req;    // ask the receiver for one long hold-off
    logic [47:0] clock_ms;    // running time stamp fed to the block
    int          quiet_cycles;

    multi_queue_admission_round_robin_top i_dut (.*);

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    // Monitor and watchdog share the rising edge: sample, then count quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{st: status_t'(status), id: out_item_id, conv: out_conversation,
                              snd: out_sender, dig: out_digest, dp: out_digest_present,
                              all_cnt: pending_all, conv_cnt: pending_this});
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // block backs up while the sender keeps offering beats
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req  = 1'b0;
                out_stall = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall = 1'b0;
            end
            else
                out_stall = 1'b0;
        end
    end

    // One input beat; returns at the falling edge after acceptance.
    task automatic send_beat(request_t t);
        action         = t.act;
        item_id        = t.id;
        conversation   = t.conv;
        sender         = t.snd;
        digest         = t.dig;
        digest_present = t.dp;
        now_ms         = t.now;
        in_valid       = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_request(t);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    task automatic send_op(action_t a, logic signed [63:0] id, logic [3:0] c, logic [3:0] s,
                           logic [31:0] d, logic dp, logic [47:0] now);
        send_beat('{act: a, id: id, conv: c, snd: s, dig: d, dp: dp, now: now});
    endtask

    // Registers change only once the block has drained.
    task automatic program_limits(logic [31:0] dup_w, logic [31:0] rmax, logic [31:0] rwin,
                                  logic [31:0] per_conv, logic [31:0] tot);
        logic [31:0] vals[5];
        vals = '{dup_w, rmax, rwin, per_conv, tot};
        in_valid = 1'b0;
        while (sb.due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    = 1'b1;
            cfg_index = i[2:0];
            cfg_data  = vals[i];
            sb.set_reg(i[2:0], vals[i]);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    // Random beat: half enqueues, mostly on few senders and digests so the checks bite.
    task automatic send_random();
        request_t    t;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        t.act = (pick < 50) ? ACT_ENQUEUE : (pick < 75) ? ACT_TAKE_NEXT :
                (pick < 90) ? ACT_TAKE_FOR : ACT_QUERY;
        t.id   = {$urandom, $urandom};
        t.conv = 4'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
        t.snd  = 4'($urandom_range(0, 2) != 0 ? $urandom_range(0, 3) : $urandom_range(0, 15));
        t.dig  = $urandom_range(0, 3) != 0 ? $urandom_range(0, 3) : $urandom;
        t.dp   = $urandom_range(0, 3) != 0;
        pick = $urandom_range(0, 99);
        if (pick == 0)
            clock_ms = clock_ms - 48'($urandom_range(1, 50));   // clock steps back
        else if (pick < 10)
            clock_ms = clock_ms + 48'($urandom_range(0, 400));
        else
            clock_ms = clock_ms + 48'($urandom_range(0, 4));
        t.now = clock_ms;
        send_beat(t);
    endtask

    initial
    begin
        sb             = new();
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        action         = '0;
        item_id        = '0;
        conversation   = '0;
        sender         = '0;
        digest         = '0;
        digest_present = 1'b0;
        now_ms         = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed, all limits off: empty takes and query, then FIFO depth on one queue.
        send_op(ACT_TAKE_NEXT, 0, 4'd0, 4'd0, 0, 1'b0, 48'd0);
        send_op(ACT_TAKE_FOR, 0, 4'd15, 4'd0, 0, 1'b0, 48'd0);
        send_op(ACT_QUERY, 0, 4'd15, 4'd0, 0, 1'b0, 48'd0);
        send_op(ACT_ENQUEUE, 64'sh7FFF_FFFF_FFFF_FFFF, 4'd15, 4'd15, 32'hFFFF_FFFF,
                1'b1, 48'hFFFF_FFFF_FFFF);
        send_op(ACT_ENQUEUE, 64'sh8000_0000_0000_0000, 4'd0, 4'd0, 32'h0, 1'b0, 48'd5);
        for (int i = 0; i < 17; i++)
            send_op(ACT_ENQUEUE, i, 4'd3, 4'd1, 32'h55, 1'b1, 48'd10);
        send_op(ACT_TAKE_NEXT, 0, 4'd3, 4'd0, 0, 1'b0, 48'd10);
        send_op(ACT_TAKE_NEXT, 0, 4'd3, 4'd0, 0, 1'b0, 48'd10);
        send_op(ACT_TAKE_FOR, 0, 4'd15, 4'd0, 0, 1'b0, 48'd10);

        // Directed, duplicate and rate checks with the clock stepping back.
        program_limits(32'd100, 32'd2, 32'd50, 32'd0, 32'd0);
        send_op(ACT_ENQUEUE, 64'sd1, 4'd7, 4'd9, 32'hABCD, 1'b1, 48'd1000);
        send_op(ACT_ENQUEUE, 64'sd2, 4'd7, 4'd9, 32'hABCD, 1'b1, 48'd1010);  // duplicate
        send_op(ACT_ENQUEUE, 64'sd3, 4'd7, 4'd9, 32'hABCD, 1'b0, 48'd1010);  // no digest
        send_op(ACT_ENQUEUE, 64'sd4, 4'd8, 4'd9, 32'h1, 1'b1, 48'd1010);     // rate cap
        send_op(ACT_ENQUEUE, 64'sd5, 4'd8, 4'd9, 32'h1, 1'b1, 48'd900);      // time back
        send_op(ACT_ENQUEUE, 64'sd6, 4'd8, 4'd9, 32'h1, 1'b1, 48'd1200);     // stamps expire
        send_op(ACT_TAKE_FOR, 0, 4'd7, 4'd0, 0, 1'b0, 48'd1200);

        // Random phases; the last one runs without gaps on either side.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: program_limits(32'd20, 32'd3, 32'd40, 32'd4, 32'd24);
                1: program_limits(32'hFFFF_FFFF, 32'd15, 32'hFFFF_FFFF, 32'd31, 32'd511);
                2: program_limits(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
                3: program_limits(32'd0, 32'd8, 32'd0, 32'd16, 32'd256);
                4: program_limits(32'd300, 32'd8, 32'd200, 32'd0, 32'd0);
                default:
                begin
                    program_limits(32'd50, 32'd2, 32'd30, 32'd8, 32'd60);
                    idle_on = 1'b0;
                end
            endcase
            clock_ms = (ph == 1) ? 48'hFFFF_FFFF_0000 : (ph == 2) ? 48'd0
                                 : 48'({$urandom, $urandom});
            for (int n = 0; n < 290; n++)
            begin
                if (ph == 0 && n == 60)
                    hold_req = 1'b1;
                send_random();
            end
        end

        in_valid = 1'b0;
        while (sb.due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
